>>> rtl/variable_width_bit_packer_macros.svh
// Assertion helpers for the bit packer.
// Sampled on clk and switched off while arst_n is low.
`ifndef VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH
`define VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH

// Same-cycle implication.
`define VWBP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VWBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/vwbp_pkg.sv
`default_nettype none
package vwbp_pkg;

	localparam int WORD_BITS = 32;
	localparam int WIDTH_BITS = 6;
	localparam int IDX_BITS = 3;
	localparam int POS_BITS = 4;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PUSH  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef logic [WORD_BITS-1:0] word_t;

endpackage
`default_nettype wire

>>> rtl/vwbp_key_mem.sv
`default_nettype none
// Key word store: one write port, one read port, registered read data.
module vwbp_key_mem
	import vwbp_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW = 3
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire word_t         wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output word_t              rd_data
);

	word_t mem_q [DEPTH];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// held until the next read so a stalled beat keeps its data
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> rtl/variable_width_bit_packer.sv
`default_nettype none
// Channel  Handshake                 Payload
// item     item_valid / item_stall   opcode, field_value, field_width, read_index
// result   result_valid / result_stall  read_word, word_position, bits_free, overflow
//
// One item per cycle sustained while item_stall is low; each beat gives one result beat,
// registered first in stage 1 (the key store read) and then in the result register.
// Reset clears the write position and the open word; the store needs no sweep.
// Words behind the write position are always written since the last clear,
// words beyond it read as zero, so clear needs no sweep of the store.
// A stalled result holds the pipe; item_stall rises only when both stages are full.
`include "variable_width_bit_packer_macros.svh"
module variable_width_bit_packer
	import vwbp_pkg::*;
#(
	parameter int KEY_WORDS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [1:0]            opcode,
	input  wire logic [WORD_BITS-1:0]  field_value,
	input  wire logic [WIDTH_BITS-1:0] field_width,
	input  wire logic [IDX_BITS-1:0]   read_index,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [WORD_BITS-1:0]       read_word,
	output logic [POS_BITS-1:0]        word_position,
	output logic [WIDTH_BITS-1:0]      bits_free,
	output logic                       overflow
);

	localparam int AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int FW = $clog2(KEY_WORDS + 1);
	localparam int CW = (FW > IDX_BITS) ? FW : IDX_BITS;
	localparam logic [FW-1:0] FILL_FULL = FW'(KEY_WORDS);
	localparam logic [FW-1:0] FILL_LAST = FW'(KEY_WORDS - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(KEY_WORDS);
	localparam logic [WIDTH_BITS-1:0] FULL_FREE = WIDTH_BITS'(WORD_BITS);

	// where a read beat takes its word from
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_MEM  = 2'd1,
		SRC_CUR  = 2'd2
	} rd_src_t;

	// packer state: the word being filled lives in cur_q, finished words in the store
	logic [FW-1:0]         fill_q;
	logic [WIDTH_BITS-1:0] free_q;
	word_t                 cur_q;

	// stage 1: store read in flight
	logic                  valid_s1;
	rd_src_t               src_s1;
	word_t                 cur_s1;
	logic [POS_BITS-1:0]   pos_s1;
	logic [WIDTH_BITS-1:0] free_s1;
	logic                  ovf_s1;

	// result register
	logic                  out_valid_q;
	word_t                 word_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [WIDTH_BITS-1:0] free_out_q;
	logic                  ovf_q;

	opcode_t               op;
	logic                  item_acc;
	logic                  out_free;
	logic                  s1_free;
	logic [WIDTH_BITS-1:0] w_c;
	word_t                 mask_c;
	word_t                 val_c;
	logic [4:0]            shift_c;
	word_t                 merged_c;
	word_t                 spill_c;
	logic                  ovf_c;
	logic                  push_ok;
	logic [FW-1:0]         fill_d;
	logic [WIDTH_BITS-1:0] free_d;
	word_t                 cur_d;
	logic                  we_c;
	logic                  mem_we;
	logic                  mem_re;
	logic [CW-1:0]         idx_c;
	logic [CW-1:0]         fillx_c;
	rd_src_t               src_c;
	word_t                 mem_rdata;

	assign op       = opcode_t'(opcode);
	assign item_acc = item_valid && !item_stall;
	assign out_free = !out_valid_q || !result_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign item_stall = !s1_free;

	// field alignment: widths above a word clamp to a full word
	assign w_c = (field_width > FULL_FREE) ? FULL_FREE : field_width;
	assign mask_c = w_c[5] ? '1 : ((word_t'(1) << w_c[4:0]) - word_t'(1));
	assign val_c = field_value & mask_c;
	assign shift_c = 5'(FULL_FREE - free_q);
	assign merged_c = cur_q | (val_c << shift_c);
	// only used when the field splits, so free_q is below a full word here
	assign spill_c = val_c >> free_q[4:0];

	// room check: nothing fits once full; a split needs a following word
	assign ovf_c = (op == OP_PUSH) && (w_c != '0)
		&& ((fill_q == FILL_FULL) || ((w_c > free_q) && (fill_q == FILL_LAST)));
	assign push_ok = (op == OP_PUSH) && (w_c != '0) && !ovf_c;

	always_comb begin
		fill_d = fill_q;
		free_d = free_q;
		cur_d  = cur_q;
		we_c   = 1'b0;
		case (op)
			OP_CLEAR: begin
				fill_d = '0;
				free_d = FULL_FREE;
				cur_d  = '0;
			end
			OP_PUSH: begin
				if (push_ok) begin
					if (free_q > w_c) begin
						cur_d  = merged_c;
						free_d = free_q - w_c;
					end else begin
						// word completes: write it back and open the next
						we_c   = 1'b1;
						fill_d = fill_q + FW'(1);
						if (free_q < w_c) begin
							cur_d  = spill_c;
							free_d = FULL_FREE - (w_c - free_q);
						end else begin
							cur_d  = '0;
							free_d = FULL_FREE;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// read source: finished words from the store, the open word from cur_q
	assign idx_c   = CW'(read_index);
	assign fillx_c = CW'(fill_q);

	always_comb begin
		src_c = SRC_ZERO;
		if ((op == OP_READ) && (idx_c < DEPTH_C)) begin
			if (idx_c < fillx_c) begin
				src_c = SRC_MEM;
			end else if (idx_c == fillx_c) begin
				src_c = SRC_CUR;
			end
		end
	end

	assign mem_we = item_acc && we_c;
	assign mem_re = item_acc && (src_c == SRC_MEM);

	vwbp_key_mem #(
		.DEPTH(KEY_WORDS),
		.AW(AW)
	) u_key_mem (
		.clk(clk),
		.wr_en(mem_we),
		.wr_addr(fill_q[AW-1:0]),
		.wr_data(merged_c),
		.rd_en(mem_re),
		.rd_addr(AW'(read_index)),
		.rd_data(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			free_q <= FULL_FREE;
			cur_q  <= '0;
		end else if (item_acc) begin
			fill_q <= fill_d;
			free_q <= free_d;
			cur_q  <= cur_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= item_acc;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			src_s1  <= src_c;
			cur_s1  <= cur_q;
			pos_s1  <= POS_BITS'(fill_d);
			free_s1 <= free_d;
			ovf_s1  <= ovf_c;
		end
		if (out_free && valid_s1) begin
			case (src_s1)
				SRC_MEM: word_q <= mem_rdata;
				SRC_CUR: word_q <= cur_s1;
				default: word_q <= '0;
			endcase
			pos_q      <= pos_s1;
			free_out_q <= free_s1;
			ovf_q      <= ovf_s1;
		end
	end

	assign result_valid  = out_valid_q;
	assign read_word     = word_q;
	assign word_position = pos_q;
	assign bits_free     = free_out_q;
	assign overflow      = ovf_q;

	`VWBP_ASSERT(a_free_range, 1'b1, (free_q != '0) && (free_q <= FULL_FREE), "free bits out of range")
	`VWBP_ASSERT(a_full_empty, fill_q == FILL_FULL, (free_q == FULL_FREE) && (cur_q == '0), "full buffer with open bits")
	`VWBP_ASSERT_NEXT(a_drop_holds, item_acc && ovf_c, $stable(fill_q) && $stable(free_q) && $stable(cur_q), "dropped push changed state")
	`VWBP_ASSERT(a_wr_in_range, mem_we, fill_q < FILL_FULL, "store write past the buffer")
	`VWBP_ASSERT_NEXT(a_read_tracked, mem_re, valid_s1 && (src_s1 == SRC_MEM), "store read lost its beat")

endmodule
`default_nettype wire

>>> bench/variable_width_bit_packer_test.sv
`timescale 1ns / 1ps
module variable_width_bit_packer_test;
	import vwbp_pkg::*;

	localparam int KEY_WORDS = 8;
	localparam int BUFFER_BITS = KEY_WORDS * WORD_BITS;
	// Opcode 3 has no meaning; the block must leave its state alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Keeps the log readable when something goes badly wrong; every miss is still counted.
	localparam int MAX_REPORT_LINES = 100;

	// What one result beat should carry.
	typedef struct packed {
		word_t                 read_word;
		logic [POS_BITS-1:0]   word_position;
		logic [WIDTH_BITS-1:0] bits_free;
		logic                  overflow;
	} packer_status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic [1:0]            opcode;
	word_t                 field_value;
	logic [WIDTH_BITS-1:0] field_width;
	logic [IDX_BITS-1:0]   read_index;
	logic                  result_valid;
	logic                  result_stall;
	word_t                 read_word;
	logic [POS_BITS-1:0]   word_position;
	logic [WIDTH_BITS-1:0] bits_free;
	logic                  overflow;

	// Shadow copy of the key buffer and write pointer.
	word_t key_store [KEY_WORDS];
	int    store_fill;
	int    store_free;

	// Status beats owed by the block, oldest first.
	packer_status_t status_due [$];

	// Percentage chance of a gap before a beat (sender) or of a stall burst (receiver).
	int idle_pct;
	int stall_pct;
	int stall_left;

	int items_sent;
	int beats_checked;
	int mismatches;
	int dropped_pushes;
	int split_fields;

	variable_width_bit_packer #(
		.KEY_WORDS(KEY_WORDS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.field_value  (field_value),
		.field_width  (field_width),
		.read_index   (read_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_word    (read_word),
		.word_position(word_position),
		.bits_free    (bits_free),
		.overflow     (overflow)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string detail);
		mismatches++;
		if (mismatches <= MAX_REPORT_LINES) begin
			$display("%0t: %s", $time, detail);
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int idle_span();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(8, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// Push widths: plenty of the awkward ones (zero, full word, above range).
	function automatic logic [WIDTH_BITS-1:0] pick_width();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			return '0;
		end else if (pick < 20) begin
			return WIDTH_BITS'(WORD_BITS);
		end else if (pick < 30) begin
			return WIDTH_BITS'($urandom_range(WORD_BITS + 1, 63));
		end
		return WIDTH_BITS'($urandom_range(1, WORD_BITS - 1));
	endfunction

	// Applies one item to the shadow buffer and returns the status it should produce.
	function automatic packer_status_t pack_field_step(input logic [1:0] op, input word_t value,
			input logic [WIDTH_BITS-1:0] width, input logic [IDX_BITS-1:0] index);
		packer_status_t status;
		int             bits;
		int             used;
		int             spill;
		word_t          kept;
		status = '0;
		case (op)
			OP_CLEAR: begin
				key_store = '{default: '0};
				store_fill = 0;
				store_free = WORD_BITS;
			end
			OP_PUSH: begin
				// Anything wider than a word is clipped to a word.
				bits = (width > WORD_BITS) ? WORD_BITS : int'(width);
				used = store_fill * WORD_BITS + (WORD_BITS - store_free);
				if (bits == 0) begin
					// zero width: nothing moves, never flagged, even when full
				end else if (used + bits > BUFFER_BITS) begin
					// not enough room left for the whole field: dropped untouched
					status.overflow = 1'b1;
					dropped_pushes++;
				end else begin
					kept = (bits == WORD_BITS) ? value : value & ((word_t'(1) << bits) - 1);
					key_store[store_fill] |= kept << (WORD_BITS - store_free);
					if (store_free > bits) begin
						store_free -= bits;
					end else if (store_free < bits) begin
						// spans two words: high part opens the next word
						spill = bits - store_free;
						key_store[store_fill + 1] = kept >> store_free;
						store_fill++;
						store_free = WORD_BITS - spill;
						split_fields++;
					end else begin
						// lands exactly on the boundary
						store_fill++;
						store_free = WORD_BITS;
					end
				end
			end
			OP_READ: begin
				if (index < KEY_WORDS) begin
					status.read_word = key_store[index];
				end
			end
			default: begin
			end
		endcase
		status.word_position = POS_BITS'(store_fill);
		status.bits_free = WIDTH_BITS'(store_free);
		return status;
	endfunction

	// Sends one item beat. Valid is only lowered when a gap is due, so back-to-back
	// beats keep it high with a single assignment per falling edge.
	task automatic send_item(input logic [1:0] op, input word_t value,
			input logic [WIDTH_BITS-1:0] width, input logic [IDX_BITS-1:0] index);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? idle_span() : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		field_value <= value;
		field_width <= width;
		read_index <= index;
		// item_stall is read before the edge's updates land
		do @(posedge clk); while (item_stall);
		status_due.push_back(pack_field_step(op, value, width, index));
		if (op != OP_UNUSED) begin
			items_sent++;
		end
	endtask

	// Receiver: stall bursts of random length, changed on the falling edge only.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= idle_span() - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Result checker: one comparison per accepted result beat.
	always @(posedge clk) begin
		packer_status_t due;
		if (arst_n && result_valid && !result_stall) begin
			beats_checked++;
			if (status_due.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding: word %h pos %0d",
					read_word, word_position));
			end else begin
				due = status_due.pop_front();
				if (read_word !== due.read_word || word_position !== due.word_position ||
						bits_free !== due.bits_free || overflow !== due.overflow) begin
					report_mismatch($sformatf(
						"beat %0d: word %h/%h pos %0d/%0d free %0d/%0d ovf %0b/%0b (got/exp)",
						beats_checked, read_word, due.read_word, word_position,
						due.word_position, bits_free, due.bits_free, overflow, due.overflow));
				end
			end
		end
	end

	// Fresh buffer reads as zero at words 0 and 7; the unused opcode is a no-op.
	task automatic test_reset_contents();
		idle_pct = 0;
		stall_pct = 0;
		send_item(OP_READ, '1, '1, 3'd0);
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(OP_READ, '0, '0, 3'd7);
	endtask

	// Field edges: zero width, full word, width above range, split and exact fill.
	task automatic test_field_edges();
		send_item(OP_PUSH, 32'hFFFF_FFFF, 6'd0, 3'd0);
		send_item(OP_PUSH, 32'hFFFF_FFFF, 6'd32, 3'd0);
		send_item(OP_PUSH, 32'hFFFF_FFFF, 6'd20, 3'd0);
		send_item(OP_PUSH, 32'h0001_2345, 6'd20, 3'd0);
		send_item(OP_PUSH, 32'hDEAD_BEEF, 6'd63, 3'd0);
		send_item(OP_PUSH, 32'h8000_0001, 6'd33, 3'd0);
		send_item(OP_PUSH, 32'h00AB_CDEF, 6'd24, 3'd0);
	endtask

	// Fill to the last bit, then a push with no room and a zero-width push while full.
	task automatic test_full_buffer();
		repeat (3) send_item(OP_PUSH, $urandom, 6'd32, 3'd0);
		send_item(OP_PUSH, 32'h1, 6'd1, 3'd0);
		send_item(OP_PUSH, '1, 6'd0, 3'd0);
		send_item(OP_READ, '0, '0, 3'd0);
		send_item(OP_READ, '0, '0, 3'd2);
		send_item(OP_READ, '0, '0, 3'd4);
		send_item(OP_READ, '0, '0, 3'd7);
		send_item(OP_CLEAR, '0, '0, 3'd0);
		send_item(OP_READ, '0, '0, 3'd0);
	endtask

	// Packing runs: clear, a burst of pushes with the odd read, clear or unused
	// opcode thrown in, then often a full read-back. Long runs hit the overflow path.
	task automatic test_random_sequences(input int count, input int idle, input int stall);
		int target;
		int pick;
		idle_pct = idle;
		stall_pct = stall;
		target = items_sent + count;
		while (items_sent < target) begin
			send_item(OP_CLEAR, $urandom, pick_width(), IDX_BITS'($urandom_range(0, 7)));
			repeat ($urandom_range(2, 30)) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					send_item(OP_PUSH, $urandom, pick_width(), IDX_BITS'($urandom_range(0, 7)));
				end else if (pick < 92) begin
					send_item(OP_READ, $urandom, pick_width(), IDX_BITS'($urandom_range(0, 7)));
				end else if (pick < 97) begin
					send_item(OP_UNUSED, $urandom, pick_width(), IDX_BITS'($urandom_range(0, 7)));
				end else begin
					send_item(OP_CLEAR, $urandom, pick_width(), IDX_BITS'($urandom_range(0, 7)));
				end
			end
			if ($urandom_range(0, 1) == 1) begin
				for (int w = 0; w < KEY_WORDS; w++) begin
					send_item(OP_READ, $urandom, pick_width(), IDX_BITS'(w));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = OP_CLEAR;
		field_value = '0;
		field_width = '0;
		read_index = '0;
		result_stall = 1'b0;
		stall_left = 0;
		idle_pct = 0;
		stall_pct = 0;
		key_store = '{default: '0};
		store_fill = 0;
		store_free = WORD_BITS;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_field_edges();
		test_full_buffer();
		// no idling, light, heavy, then a receiver that stalls most of the time
		test_random_sequences(150, 0, 0);
		test_random_sequences(200, 15, 15);
		test_random_sequences(150, 40, 40);
		test_random_sequences(150, 5, 60);

		@(negedge clk);
		item_valid <= 1'b0;
		stall_pct = 10;
		while (status_due.size() != 0) @(posedge clk);
		// let the two-stage pipe drain of anything unexpected
		repeat (8) @(posedge clk);

		$display("Sent %0d items, checked %0d result beats.", items_sent, beats_checked);
		$display("Pushes dropped for lack of room: %0d; fields split across words: %0d.",
			dropped_pushes, split_fields);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Timed out with %0d result beats outstanding", status_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
